// ===== rtl/core/mst_pkg.sv =====
// Shared types and codes for the match span table.
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;

  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int POSITION_BITS_DEF = 48;
  localparam int REQ_W             = 3;
  localparam int SLOT_W            = 8;
  localparam int STATUS_W          = 2;
  localparam int COUNT_OUT_W       = 9;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_ADDR_W        = 4;

  localparam logic [REQ_W-1:0] REQ_ADD       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_EXT_START = 3'd1;
  localparam logic [REQ_W-1:0] REQ_EXT_END   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PURGE     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SORT      = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // register select bit of paddr (registers sit 8 bytes apart)
  localparam logic REG_CONTENT_FIRST = 1'b0;
  localparam logic REG_CONTENT_LAST  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_RD_SLOT,
    OP_PREP,
    OP_COMMIT,
    OP_WRD,
    OP_CLR_WR,
    OP_PRG_WR,
    OP_PRG_END,
    OP_PASS_INIT,
    OP_S_LOAD,
    OP_S_STEP,
    OP_S_TAIL,
    OP_D_END,
    OP_D_LOAD,
    OP_D_STEP
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_SLOT,
    S_PREP,
    S_COMMIT,
    S_CLR_RD,
    S_CLR_WR,
    S_PRG_RD,
    S_PRG_WR,
    S_PRG_END,
    S_SRT_START,
    S_SRT_RD0,
    S_SRT_LOAD,
    S_SRT_RD,
    S_SRT_STEP,
    S_SRT_TAIL,
    S_DED_START,
    S_DED_RD0,
    S_DED_LOAD,
    S_DED_RD,
    S_DED_STEP,
    S_DED_END,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic             idx_end;
    logic             count_le1;
    logic             count_zero;
    logic             swapped;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/mst_datapath.sv =====
// Datapath of the match span table: entry memory, counters, checks.
`timescale 1ns / 1ps
`default_nettype none
module mst_datapath #(
  parameter int TABLE_DEPTH   = mst_pkg::TABLE_DEPTH_DEF,
  parameter int POSITION_BITS = mst_pkg::POSITION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mst_pkg::dp_op_t              op,
  input  wire logic [mst_pkg::REQ_W-1:0]    req_type,
  input  wire logic [mst_pkg::SLOT_W-1:0]   slot,
  input  wire logic [POSITION_BITS-1:0]     position,
  input  wire logic [POSITION_BITS-1:0]     span_length,
  input  wire logic [POSITION_BITS-1:0]     content_first,
  input  wire logic [POSITION_BITS-1:0]     content_last,
  output mst_pkg::dp_sts_t                  sts,
  output logic [mst_pkg::STATUS_W-1:0]      status,
  output logic [mst_pkg::COUNT_OUT_W-1:0]   entry_count,
  output logic [POSITION_BITS-1:0]          entry_first,
  output logic [POSITION_BITS-1:0]          entry_last,
  output logic                              entry_alive,
  output logic                              abort_flag
);
  import mst_pkg::*;

  localparam int PB  = POSITION_BITS;
  localparam int EW  = 2 * PB + 1;
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SW  = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int OCW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  logic [EW-1:0] mem [TABLE_DEPTH];

  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [PB-1:0]       pos_r, pos_nxt, len_r, len_nxt;
  logic [CW-1:0]       count_r, count_nxt, idx_r, idx_nxt, kept_r, kept_nxt;
  logic                abort_r, abort_nxt, swapped_r, swapped_nxt;
  logic [EW-1:0]       carry_r, carry_nxt, rd_q;
  logic [PB-1:0]       cf_r, cf_nxt, cl_r, cl_nxt;
  logic                ovf_r, ovf_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [PB-1:0]       of_r, of_nxt, ol_r, ol_nxt;
  logic                oa_r, oa_nxt;

  logic          mem_we, mem_re;
  logic [CW-1:0] wa;
  logic [AW-1:0] ra;
  logic [EW-1:0] wd;

  logic [PB-1:0] rd_first, rd_last, cy_first, cy_last;
  logic          rd_alive, cy_alive;
  logic          slot_ok, range_bad, full, carry_gt;
  logic [OCW-1:0] count_ext;

  assign rd_first = rd_q[EW-1 -: PB];
  assign rd_last  = rd_q[PB:1];
  assign rd_alive = rd_q[0];
  assign cy_first = carry_r[EW-1 -: PB];
  assign cy_last  = carry_r[PB:1];
  assign cy_alive = carry_r[0];

  assign slot_ok   = slot_r < SW'(count_r);
  assign range_bad = ovf_r || (cf_r < content_first) || (cl_r > content_last);
  assign full      = count_r >= CW'(TABLE_DEPTH);
  // strict order on (start, end, mark)
  assign carry_gt  = (cy_first != rd_first) ? (cy_first > rd_first) :
                     (cy_last != rd_last)   ? (cy_last > rd_last) :
                     (cy_alive && !rd_alive);

  assign ra = (op == OP_RD_SLOT) ? slot_r[AW-1:0] : idx_r[AW-1:0];
  assign mem_re = (op == OP_RD_SLOT) || (op == OP_WRD);

  always_comb begin
    req_nxt     = req_r;
    slot_nxt    = slot_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    abort_nxt   = abort_r;
    idx_nxt     = idx_r;
    kept_nxt    = kept_r;
    swapped_nxt = swapped_r;
    carry_nxt   = carry_r;
    cf_nxt      = cf_r;
    cl_nxt      = cl_r;
    ovf_nxt     = ovf_r;
    st_nxt      = st_r;
    of_nxt      = of_r;
    ol_nxt      = ol_r;
    oa_nxt      = oa_r;
    mem_we      = 1'b0;
    wa          = idx_r;
    wd          = rd_q;
    case (op)
      OP_LATCH: begin
        req_nxt  = req_type;
        slot_nxt = SW'(slot);
        pos_nxt  = position;
        len_nxt  = span_length;
        idx_nxt  = '0;
        kept_nxt = '0;
        st_nxt   = ST_OK;
        of_nxt   = '0;
        ol_nxt   = '0;
        oa_nxt   = 1'b0;
      end
      OP_PREP: begin
        ovf_nxt = 1'b0;
        cf_nxt  = pos_r;
        cl_nxt  = rd_last;
        if (req_r == REQ_EXT_END) begin
          cf_nxt = rd_first;
          cl_nxt = pos_r;
        end else if (req_r != REQ_EXT_START) begin
          {ovf_nxt, cl_nxt} = {1'b0, pos_r} + {1'b0, len_r};
        end
      end
      OP_COMMIT: begin
        case (req_r)
          REQ_ADD, REQ_EXT_START, REQ_EXT_END: begin
            if (req_r != REQ_ADD && !slot_ok) begin
              st_nxt = ST_INDEX;
            end else if (req_r != REQ_ADD && !rd_alive) begin
              wa = slot_r[CW-1:0];
              if (req_r == REQ_EXT_START) begin
                wd = {pos_r, rd_last, 1'b1};
                if (pos_r < content_first) st_nxt = ST_RANGE;
                else mem_we = 1'b1;
              end else begin
                wd = {rd_first, pos_r, 1'b1};
                if (pos_r > content_last) st_nxt = ST_RANGE;
                else mem_we = 1'b1;
              end
            end else if (range_bad) begin
              st_nxt = ST_RANGE;
            end else if (full) begin
              st_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              wa        = count_r;
              wd        = {cf_r, cl_r, 1'b1};
              count_nxt = count_r + 1'b1;
            end
          end
          REQ_READ: begin
            if (!slot_ok) begin
              st_nxt = ST_INDEX;
            end else begin
              of_nxt = rd_first;
              ol_nxt = rd_last;
              oa_nxt = rd_alive;
            end
          end
          default: ;
        endcase
      end
      OP_CLR_WR: begin
        mem_we  = 1'b1;
        wd      = {rd_first, rd_last, 1'b0};
        idx_nxt = idx_r + 1'b1;
      end
      OP_PRG_WR: begin
        if (rd_alive) begin
          mem_we   = 1'b1;
          wa       = kept_r;
          kept_nxt = kept_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
      end
      OP_PRG_END: begin
        count_nxt = kept_r;
        abort_nxt = (kept_r == '0);
      end
      OP_PASS_INIT: begin
        idx_nxt     = '0;
        swapped_nxt = 1'b0;
      end
      OP_S_LOAD, OP_D_LOAD: begin
        carry_nxt = rd_q;
        idx_nxt   = CW'(1);
        kept_nxt  = CW'(1);
      end
      OP_S_STEP: begin
        mem_we = 1'b1;
        wa     = idx_r - 1'b1;
        if (carry_gt) begin
          wd          = rd_q;
          swapped_nxt = 1'b1;
        end else begin
          wd        = carry_r;
          carry_nxt = rd_q;
        end
        idx_nxt = idx_r + 1'b1;
      end
      OP_S_TAIL: begin
        mem_we = 1'b1;
        wa     = count_r - 1'b1;
        wd     = carry_r;
      end
      // walk done: the kept entries become the table
      OP_D_END: count_nxt = kept_r;
      OP_D_STEP: begin
        if (rd_first != cy_first || rd_last != cy_last) begin
          mem_we    = 1'b1;
          wa        = kept_r;
          kept_nxt  = kept_r + 1'b1;
          carry_nxt = rd_q;
        end
        idx_nxt = idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wa[AW-1:0]] <= wd;
    if (mem_re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      abort_r   <= 1'b0;
      idx_r     <= '0;
      kept_r    <= '0;
      swapped_r <= 1'b0;
      req_r     <= '0;
      st_r      <= ST_OK;
    end else begin
      count_r   <= count_nxt;
      abort_r   <= abort_nxt;
      idx_r     <= idx_nxt;
      kept_r    <= kept_nxt;
      swapped_r <= swapped_nxt;
      req_r     <= req_nxt;
      st_r      <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    pos_r   <= pos_nxt;
    len_r   <= len_nxt;
    carry_r <= carry_nxt;
    cf_r    <= cf_nxt;
    cl_r    <= cl_nxt;
    ovf_r   <= ovf_nxt;
    of_r    <= of_nxt;
    ol_r    <= ol_nxt;
    oa_r    <= oa_nxt;
  end

  assign count_ext = OCW'(count_r);

  assign sts.idx_end    = (idx_r == count_r);
  assign sts.count_le1  = (count_r <= CW'(1));
  assign sts.count_zero = (count_r == '0);
  assign sts.swapped    = swapped_r;

  assign status      = st_r;
  assign entry_count = count_ext[COUNT_OUT_W-1:0];
  assign entry_first = of_r;
  assign entry_last  = ol_r;
  assign entry_alive = oa_r;
  assign abort_flag  = abort_r;

endmodule
`default_nettype wire

// ===== rtl/core/mst_ctrl.sv =====
// Request sequencer of the match span table.
`timescale 1ns / 1ps
`default_nettype none
module mst_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [mst_pkg::REQ_W-1:0] in_req_type,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire mst_pkg::dp_sts_t sts,
  output mst_pkg::dp_op_t       op
);
  import mst_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_CLEAR: state_nxt = S_CLR_RD;
            REQ_PURGE: state_nxt = S_PRG_RD;
            REQ_SORT:  state_nxt = S_SRT_START;
            REQ_ADD, REQ_EXT_START, REQ_EXT_END, REQ_READ: state_nxt = S_RD_SLOT;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_RD_SLOT:   state_nxt = S_PREP;
      S_PREP:      state_nxt = S_COMMIT;
      S_COMMIT:    state_nxt = S_DONE;
      S_CLR_RD:    state_nxt = sts.idx_end ? S_DONE : S_CLR_WR;
      S_CLR_WR:    state_nxt = S_CLR_RD;
      S_PRG_RD:    state_nxt = sts.idx_end ? S_PRG_END : S_PRG_WR;
      S_PRG_WR:    state_nxt = S_PRG_RD;
      S_PRG_END:   state_nxt = S_DONE;
      S_SRT_START: state_nxt = sts.count_le1 ? S_DED_START : S_SRT_RD0;
      S_SRT_RD0:   state_nxt = S_SRT_LOAD;
      S_SRT_LOAD:  state_nxt = S_SRT_RD;
      S_SRT_RD:    state_nxt = sts.idx_end ? S_SRT_TAIL : S_SRT_STEP;
      S_SRT_STEP:  state_nxt = S_SRT_RD;
      S_SRT_TAIL:  state_nxt = sts.swapped ? S_SRT_START : S_DED_START;
      S_DED_START: state_nxt = sts.count_zero ? S_DONE : S_DED_RD0;
      S_DED_RD0:   state_nxt = S_DED_LOAD;
      S_DED_LOAD:  state_nxt = S_DED_RD;
      S_DED_RD:    state_nxt = sts.idx_end ? S_DED_END : S_DED_STEP;
      S_DED_STEP:  state_nxt = S_DED_RD;
      S_DED_END:   state_nxt = S_DONE;
      S_DONE:      state_nxt = out_ready ? S_IDLE : S_DONE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op        = OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LATCH;
      end
      S_RD_SLOT:   op = OP_RD_SLOT;
      S_PREP:      op = OP_PREP;
      S_COMMIT:    op = OP_COMMIT;
      S_CLR_RD:    op = sts.idx_end ? OP_NONE : OP_WRD;
      S_CLR_WR:    op = OP_CLR_WR;
      S_PRG_RD:    op = sts.idx_end ? OP_NONE : OP_WRD;
      S_PRG_WR:    op = OP_PRG_WR;
      S_PRG_END:   op = OP_PRG_END;
      S_SRT_START: op = sts.count_le1 ? OP_NONE : OP_PASS_INIT;
      S_SRT_RD0:   op = OP_WRD;
      S_SRT_LOAD:  op = OP_S_LOAD;
      S_SRT_RD:    op = sts.idx_end ? OP_NONE : OP_WRD;
      S_SRT_STEP:  op = OP_S_STEP;
      S_SRT_TAIL:  op = OP_S_TAIL;
      S_DED_START: op = sts.count_zero ? OP_NONE : OP_PASS_INIT;
      S_DED_RD0:   op = OP_WRD;
      S_DED_LOAD:  op = OP_D_LOAD;
      S_DED_RD:    op = sts.idx_end ? OP_NONE : OP_WRD;
      S_DED_STEP:  op = OP_D_STEP;
      S_DED_END:   op = OP_D_END;
      S_DONE:      out_valid = 1'b1;
      default:     op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/match_span_table_top.sv =====
// Top level of the match span table: config registers, sequencer, datapath.
// The block holds up to TABLE_DEPTH spans (start, end, live mark) in one
// single-port-write, registered-read memory and serves one request at a time.
// A beat is taken only when the block is idle; its result beat is held until
// taken. Add, extend and read go through latch, memory read, end-point add,
// check and write, and result. Clear marks does one memory read and one write
// per held entry; purge reads each held entry and writes only the live ones
// back, packed to the front. Sort is a bubble sort over the memory, at most N
// passes for N held entries, followed by a dedup walk. Memory contents are
// not cleared at reset: only entries below the held count are ever used.
// Config: content_first at paddr 0, content_last at paddr 8, 64-bit data.
`timescale 1ns / 1ps
`default_nettype none
module match_span_table_top #(
  parameter int TABLE_DEPTH   = mst_pkg::TABLE_DEPTH_DEF,
  parameter int POSITION_BITS = mst_pkg::POSITION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mst_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [mst_pkg::SLOT_W-1:0]       in_slot,
  input  wire logic [POSITION_BITS-1:0]         in_position,
  input  wire logic [POSITION_BITS-1:0]         in_span_length,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mst_pkg::STATUS_W-1:0]          out_status,
  output logic [mst_pkg::COUNT_OUT_W-1:0]       out_entry_count,
  output logic [POSITION_BITS-1:0]              out_entry_first,
  output logic [POSITION_BITS-1:0]              out_entry_last,
  output logic                                  out_entry_alive,
  output logic                                  out_abort_flag,
  // APB config port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mst_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [mst_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mst_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import mst_pkg::*;

  logic [POSITION_BITS-1:0] content_first_r, content_last_r;
  logic                     cfg_we;
  logic                     cfg_sel;
  dp_op_t                   op;
  dp_sts_t                  sts;

  // registers are 8 bytes apart; bit 3 picks one
  assign cfg_sel = paddr[3];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      content_first_r <= '0;
      content_last_r  <= '1;
    end else if (cfg_we) begin
      if (cfg_sel == REG_CONTENT_FIRST) content_first_r <= pwdata[POSITION_BITS-1:0];
      else content_last_r <= pwdata[POSITION_BITS-1:0];
    end
  end

  always_comb begin
    if (cfg_sel == REG_CONTENT_LAST) prdata = CFG_DATA_W'(content_last_r);
    else prdata = CFG_DATA_W'(content_first_r);
  end

  // sequencer: walks and per-request steps
  mst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .op         (op)
  );

  // table memory, counts and result registers
  mst_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .POSITION_BITS(POSITION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .req_type     (in_req_type),
    .slot         (in_slot),
    .position     (in_position),
    .span_length  (in_span_length),
    .content_first(content_first_r),
    .content_last (content_last_r),
    .sts          (sts),
    .status       (out_status),
    .entry_count  (out_entry_count),
    .entry_first  (out_entry_first),
    .entry_last   (out_entry_last),
    .entry_alive  (out_entry_alive),
    .abort_flag   (out_abort_flag)
  );

endmodule
`default_nettype wire
